### rtl/xdts_pkg.sv
package xdts_pkg;

  // default tag buffer depth (one slot is kept spare, as the tag text is cut at depth - 1)
  localparam int TAG_BYTES_DEF = 32;

  // character codes seen by the parser
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_AT  = 8'h40;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_H   = 8'h48;

  // tag handling modes
  localparam logic [1:0] MODE_EH_STOP = 2'd1;
  localparam logic [1:0] MODE_REPLAY  = 2'd2;

  // markup parser phase
  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_PCT = 2'd1,
    PH_IN  = 2'd2,
    PH_AT  = 2'd3
  } phase_t;

  // result sequencer state
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_WRITE2    = 4'd1,
    ST_PCT       = 4'd2,
    ST_CHAR      = 4'd3,
    ST_OPEN_PCT  = 4'd4,
    ST_OPEN_AT   = 4'd5,
    ST_BODY      = 4'd6,
    ST_CLOSE_AT  = 4'd7,
    ST_CLOSE_PCT = 4'd8,
    ST_NEWLINE   = 4'd9
  } state_t;

  // work planned for one accepted byte
  typedef struct packed {
    logic write2;
    logic pct;
    logic chr;
    logic replay;
    logic newline;
  } plan_t;

  // map of seven codes to Latin-1 accented letters and signs, other codes unchanged
  function automatic logic [7:0] latin1_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h82:   r = 8'he9;
      8'h85:   r = 8'he0;
      8'h89:   r = 8'heb;
      8'h8a:   r = 8'he8;
      8'ha4:   r = 8'hf1;
      8'hf8:   r = 8'hb0;
      8'hf9:   r = 8'hb7;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

### rtl/xdts_decode.sv
module xdts_decode (
  input  logic [7:0] scrambled_byte,
  input  logic [8:0] offset_low,
  output logic [7:0] plain_char
);
  import xdts_pkg::*;

  logic [7:0] key;

  // key is the offset halved, low eight bits
  assign key        = offset_low[8:1];
  assign plain_char = latin1_map(scrambled_byte ^ key);

endmodule

### rtl/xdts_tag_ram.sv
module xdts_tag_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/xor_descramble_tag_stripper_core.sv
// Descrambles one dictionary byte per input transfer (XOR with offset_low >> 1, then the
// Latin-1 letter map), strips %@tag@% markup and emits the printable result as a stream of
// characters and line breaks, out_last marking the final result of each byte. The tag text
// is held in a single-port-write, registered-read RAM of TAG_BYTES entries. Items are taken
// one at a time: a new byte is not accepted until all results of the last one are issued,
// with an extra write step when an inner '@' stores two bytes (the RAM has one write port),
// and a mode-2 tag replay holds the input until the whole tag is replayed. tag_mode must
// be written through cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
module xor_descramble_tag_stripper_core #(
  parameter int TAG_BYTES = xdts_pkg::TAG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scrambled_byte,
  input  logic [8:0] offset_low,
  input  logic       entry_first,
  input  logic       entry_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code,
  output logic       out_newline,
  output logic       out_last
);
  import xdts_pkg::*;

  localparam int AW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam logic [AW-1:0] LEN_MAX = AW'(TAG_BYTES - 1);

  logic [1:0]    tag_mode;
  phase_t        phase, phase_next;
  logic [AW-1:0] tag_len, tag_len_next;
  logic          stopped, stopped_next;
  logic          tag_e, tag_h;
  state_t        state, state_next;
  plan_t         plan, plan_next;
  logic [7:0]    chr, chr_next;
  logic [AW-1:0] idx, idx_next;

  logic [7:0]    dec_char;
  logic [7:0]    rd_data;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  phase_t        eff_phase;
  logic [AW-1:0] eff_len;
  logic          eff_stopped;
  logic          slot_free;
  logic          emit_req;
  logic [7:0]    emit_code;
  logic          emit_nl;
  logic          emit_last;

  // first state of the result sequence for a plan
  function automatic state_t first_state(input plan_t p);
    state_t s;
    if (p.write2) begin
      s = ST_WRITE2;
    end else if (p.pct) begin
      s = ST_PCT;
    end else if (p.chr) begin
      s = ST_CHAR;
    end else if (p.replay) begin
      s = ST_OPEN_PCT;
    end else if (p.newline) begin
      s = ST_NEWLINE;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  xdts_decode u_decode (
    .scrambled_byte (scrambled_byte),
    .offset_low     (offset_low),
    .plain_char     (dec_char)
  );

  xdts_tag_ram #(
    .DEPTH (TAG_BYTES),
    .AW    (AW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // entry start clears parser state ahead of the byte
  assign eff_phase   = entry_first ? PH_RUN : phase;
  assign eff_len     = entry_first ? '0 : tag_len;
  assign eff_stopped = entry_first ? 1'b0 : stopped;

  // parser update, RAM writes and result sequencing
  always_comb begin
    state_next   = state;
    plan_next    = plan;
    phase_next   = phase;
    tag_len_next = tag_len;
    stopped_next = stopped;
    chr_next     = chr;
    idx_next     = '0;
    we           = 1'b0;
    waddr        = tag_len;
    wdata        = chr;
    emit_req     = 1'b0;
    emit_code    = 8'h00;
    emit_nl      = 1'b0;
    emit_last    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          plan_next    = '0;
          phase_next   = eff_phase;
          tag_len_next = eff_len;
          stopped_next = eff_stopped;
          chr_next     = dec_char;
          waddr        = eff_len;
          if (!eff_stopped) begin
            unique case (eff_phase)
              PH_RUN: begin
                if (dec_char == CH_PCT) begin
                  tag_len_next = '0;
                  phase_next   = PH_PCT;
                end else begin
                  plan_next.chr = 1'b1;
                end
              end
              PH_PCT: begin
                if (dec_char == CH_AT) begin
                  phase_next = PH_IN;
                end else begin
                  plan_next.pct = 1'b1;
                  plan_next.chr = 1'b1;
                  phase_next    = PH_RUN;
                end
              end
              PH_IN: begin
                if (dec_char == CH_AT) begin
                  phase_next = PH_AT;
                end else if (eff_len != LEN_MAX) begin
                  we           = 1'b1;
                  wdata        = dec_char;
                  tag_len_next = eff_len + AW'(1);
                end
              end
              PH_AT: begin
                if (dec_char == CH_PCT) begin
                  phase_next = PH_RUN;
                  if (tag_mode == MODE_EH_STOP && eff_len == AW'(2) && tag_e && tag_h) begin
                    stopped_next = 1'b1;
                  end else if (tag_mode == MODE_REPLAY) begin
                    plan_next.replay = 1'b1;
                  end
                end else begin
                  // inner at: store '@' now, the byte on the next cycle if room remains
                  phase_next = PH_IN;
                  if (eff_len != LEN_MAX) begin
                    we           = 1'b1;
                    wdata        = CH_AT;
                    tag_len_next = eff_len + AW'(1);
                    plan_next.write2 = (eff_len + AW'(1)) != LEN_MAX;
                  end
                end
              end
              default: ;
            endcase
            plan_next.newline = stopped_next || entry_last;
          end
          state_next = first_state(plan_next);
        end
      end
      ST_WRITE2: begin
        we           = 1'b1;
        tag_len_next = tag_len + AW'(1);
        state_next   = plan.newline ? ST_NEWLINE : ST_IDLE;
      end
      ST_PCT: begin
        emit_req   = 1'b1;
        emit_code  = CH_PCT;
        state_next = ST_CHAR;
      end
      ST_CHAR: begin
        emit_req   = 1'b1;
        emit_nl    = (chr == CH_NL);
        emit_code  = emit_nl ? 8'h00 : chr;
        emit_last  = !plan.newline;
        state_next = plan.newline ? ST_NEWLINE : ST_IDLE;
      end
      ST_OPEN_PCT: begin
        emit_req   = 1'b1;
        emit_code  = CH_PCT;
        state_next = ST_OPEN_AT;
      end
      ST_OPEN_AT: begin
        emit_req   = 1'b1;
        emit_code  = CH_AT;
        state_next = (tag_len == '0) ? ST_CLOSE_AT : ST_BODY;
      end
      ST_BODY: begin
        // RAM read is registered: data for idx arrives in the cycle after idx is presented
        emit_req  = 1'b1;
        emit_code = rd_data;
        if (slot_free) begin
          idx_next = idx + AW'(1);
          if (idx + AW'(1) == tag_len) begin
            state_next = ST_CLOSE_AT;
          end
        end else begin
          idx_next = idx;
        end
      end
      ST_CLOSE_AT: begin
        emit_req   = 1'b1;
        emit_code  = CH_AT;
        state_next = ST_CLOSE_PCT;
      end
      ST_CLOSE_PCT: begin
        emit_req   = 1'b1;
        emit_code  = CH_PCT;
        emit_last  = !plan.newline;
        state_next = plan.newline ? ST_NEWLINE : ST_IDLE;
      end
      ST_NEWLINE: begin
        emit_req   = 1'b1;
        emit_nl    = 1'b1;
        emit_last  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // hold the sequence while the output register is full
    if (emit_req && !slot_free) begin
      state_next = state;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      plan     <= '0;
      phase    <= PH_RUN;
      tag_len  <= '0;
      stopped  <= 1'b0;
      idx      <= '0;
      tag_mode <= 2'd0;
    end else begin
      state   <= state_next;
      plan    <= plan_next;
      phase   <= phase_next;
      tag_len <= tag_len_next;
      stopped <= stopped_next;
      idx     <= idx_next;
      if (cfg_we) begin
        tag_mode <= cfg_wdata;
      end
    end
  end

  // decoded byte and flags that the first two tag bytes are E and H, for the stop check
  always_ff @(posedge clk) begin
    chr <= chr_next;
    if (we && waddr == AW'(0)) begin
      tag_e <= (wdata == CH_E);
    end
    if (we && waddr == AW'(1)) begin
      tag_h <= (wdata == CH_H);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_req && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && slot_free) begin
      out_code    <= emit_code;
      out_newline <= emit_nl;
      out_last    <= emit_last;
    end
  end

endmodule

### rtl/xdts_checker.sv
module xdts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_code,
  input logic       out_newline,
  input logic       out_last
);

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a pending non-final result means the byte is still in work
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken before all results of a byte were produced");

  // line breaks carry a zero code
  a_newline_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_newline |-> out_code == 8'h00)
    else $error("line break with non-zero code");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_newline)
      && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind xor_descramble_tag_stripper_core xdts_checker u_xdts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_code    (out_code),
  .out_newline (out_newline),
  .out_last    (out_last)
);

### tb/xdts_glyph_checker.sv
module xdts_glyph_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] scrambled_byte,
  input  logic [8:0] offset_low,
  input  logic       entry_first,
  input  logic       entry_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_code,
  input  logic       out_newline,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import xdts_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       newline;
    logic       last;
  } glyph_t;

  // glyphs still owed by the block, oldest first
  glyph_t     glyph_q[$];
  // glyphs produced by the transfer being predicted
  glyph_t     staged[$];

  // predictor copy of the block state
  logic [1:0] tag_mode;
  phase_t     phase;
  logic [7:0] tag_text[TAG_BYTES_DEF];
  int         tag_len;
  logic       stopped;

  initial begin
    fail_count = 0;
    pending    = 0;
    tag_mode   = '0;
    phase      = PH_RUN;
    tag_len    = 0;
    stopped    = 1'b0;
  end

  function automatic void emit(input logic [7:0] code, input logic nl);
    glyph_t g;
    g.code    = nl ? 8'h00 : code;
    g.newline = nl;
    g.last    = 1'b0;
    staged.push_back(g);
  endfunction

  // running text, a decoded line feed becomes a line break
  function automatic void emit_text(input logic [7:0] c);
    if (c == CH_NL) begin
      emit(8'h00, 1'b1);
    end else begin
      emit(c, 1'b0);
    end
  endfunction

  // tag text is cut one short of the store depth
  function automatic void tag_append(input logic [7:0] c);
    if (tag_len < TAG_BYTES_DEF - 1) begin
      tag_text[tag_len] = c;
      tag_len++;
    end
  endfunction

  task automatic predict_transfer(input logic [7:0] sb, input logic [8:0] off,
                                  input logic first, input logic last);
    logic [7:0] plain;
    logic [7:0] c;
    glyph_t     g;
    int         k;
    staged.delete();
    if (first) begin
      phase   = PH_RUN;
      tag_len = 0;
      stopped = 1'b0;
    end
    if (!stopped) begin
      // descramble and map accented letters
      plain = sb ^ off[8:1];
      case (plain)
        8'h82:   c = 8'he9;
        8'h85:   c = 8'he0;
        8'h89:   c = 8'heb;
        8'h8a:   c = 8'he8;
        8'ha4:   c = 8'hf1;
        8'hf8:   c = 8'hb0;
        8'hf9:   c = 8'hb7;
        default: c = plain;
      endcase
      // markup parser
      case (phase)
        PH_RUN: begin
          if (c == CH_PCT) begin
            tag_len = 0;
            phase   = PH_PCT;
          end else begin
            emit_text(c);
          end
        end
        PH_PCT: begin
          if (c == CH_AT) begin
            phase = PH_IN;
          end else begin
            emit(CH_PCT, 1'b0);
            phase = PH_RUN;
            emit_text(c);
          end
        end
        PH_IN: begin
          if (c == CH_AT) begin
            phase = PH_AT;
          end else begin
            tag_append(c);
          end
        end
        default: begin
          if (c == CH_PCT) begin
            if (tag_mode == MODE_EH_STOP && tag_len == 2 &&
                tag_text[0] == CH_E && tag_text[1] == CH_H) begin
              emit(8'h00, 1'b1);
              stopped = 1'b1;
            end else if (tag_mode == MODE_REPLAY) begin
              emit(CH_PCT, 1'b0);
              emit(CH_AT, 1'b0);
              for (k = 0; k < tag_len; k++) emit(tag_text[k], 1'b0);
              emit(CH_AT, 1'b0);
              emit(CH_PCT, 1'b0);
            end
            phase = PH_RUN;
          end else begin
            // inner at sign stays part of the tag
            tag_append(CH_AT);
            tag_append(c);
            phase = PH_IN;
          end
        end
      endcase
    end
    if (last && !stopped) emit(8'h00, 1'b1);
    foreach (staged[i]) begin
      g      = staged[i];
      g.last = (i == staged.size() - 1);
      glyph_q.push_back(g);
    end
  endtask

  // follow both channels at each rising edge
  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      tag_mode = '0;
      phase    = PH_RUN;
      tag_len  = 0;
      stopped  = 1'b0;
      glyph_q.delete();
    end else begin
      if (cfg_we) tag_mode = cfg_wdata;
      if (in_valid && in_ready) begin
        predict_transfer(scrambled_byte, offset_low, entry_first, entry_last);
      end
      if (out_valid && out_ready) begin
        if (glyph_q.size() == 0) begin
          $display("%0t: result with nothing expected, code %02h newline %0b last %0b",
                   $time, out_code, out_newline, out_last);
          fail_count++;
        end else begin
          want = glyph_q.pop_front();
          if (out_code !== want.code) begin
            $display("%0t: out_code expected %02h actual %02h", $time, want.code, out_code);
            fail_count++;
          end
          if (out_newline !== want.newline) begin
            $display("%0t: out_newline expected %0b actual %0b",
                     $time, want.newline, out_newline);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending = glyph_q.size();
  end

endmodule

### tb/xor_descramble_tag_stripper_core_tb.sv
module xor_descramble_tag_stripper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xdts_pkg::*;

  localparam logic [1:0] MODE_DROP  = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 224;
  localparam int RANDOM_PHASES = 7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] scrambled_byte;
  logic [8:0] offset_low;
  logic       entry_first;
  logic       entry_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_code;
  logic       out_newline;
  logic       out_last;
  int         fail_count;
  int         pending;

  int         cycle_count = 0;
  int         items_sent  = 0;
  bit         hold_req    = 1'b0;
  bit         no_gaps     = 1'b0;
  logic [8:0] file_pos;
  logic [7:0] entry_bytes[$];

  xor_descramble_tag_stripper_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .scrambled_byte (scrambled_byte),
    .offset_low     (offset_low),
    .entry_first    (entry_first),
    .entry_last     (entry_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code       (out_code),
    .out_newline    (out_newline),
    .out_last       (out_last)
  );

  xdts_glyph_checker glyph_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .scrambled_byte (scrambled_byte),
    .offset_low     (offset_low),
    .entry_first    (entry_first),
    .entry_last     (entry_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code       (out_code),
    .out_newline    (out_newline),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result sink: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int pause;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      pause = no_gaps ? 0 : $urandom_range(0, 5);
      if (pause > 0) begin
        out_ready = 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // codes that the letter map turns into accented letters and signs
  function automatic logic [7:0] accent_src(input int k);
    case (k)
      0:       return 8'h82;
      1:       return 8'h85;
      2:       return 8'h89;
      3:       return 8'h8a;
      4:       return 8'ha4;
      5:       return 8'hf8;
      default: return 8'hf9;
    endcase
  endfunction

  function automatic logic [7:0] letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] random_text_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
      5:             return accent_src($urandom_range(0, 6));
      6:             return CH_NL;
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // %@body@% markup, left open when closed is clear
  function automatic void add_tag(input bit closed);
    int body_len;
    int k;
    entry_bytes.push_back(CH_PCT);
    entry_bytes.push_back(CH_AT);
    case ($urandom_range(0, 9))
      0, 1: begin
        entry_bytes.push_back(CH_E);
        entry_bytes.push_back(CH_H);
        body_len = 0;
      end
      2:       body_len = $urandom_range(28, 40);
      3:       body_len = 0;
      default: body_len = $urandom_range(1, 6);
    endcase
    for (k = 0; k < body_len; k++) begin
      if ($urandom_range(0, 7) == 0) entry_bytes.push_back(CH_AT);
      entry_bytes.push_back(letter());
    end
    if (closed) begin
      entry_bytes.push_back(CH_AT);
      entry_bytes.push_back(CH_PCT);
    end else if ($urandom_range(0, 1)) begin
      entry_bytes.push_back(CH_AT);
    end
  endfunction

  // one input transfer; the raw byte is scrambled with the running offset
  task automatic send_byte(input logic [7:0] raw, input logic first, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    scrambled_byte = raw ^ file_pos[8:1];
    offset_low     = file_pos;
    entry_first    = first;
    entry_last     = last;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    file_pos = file_pos + 9'd1;
    items_sent++;
  endtask

  // mostly well-formed entries with random text and markup
  task automatic send_entry();
    int pieces;
    int p;
    bit first_flag;
    bit last_flag;
    entry_bytes.delete();
    pieces = $urandom_range(1, 4);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 3)) entry_bytes.push_back(random_text_char());
        4, 5, 6:    add_tag(1'b1);
        7: begin
          // lone percent, dangling when it ends the entry
          entry_bytes.push_back(CH_PCT);
          if (p < pieces - 1 || $urandom_range(0, 1)) entry_bytes.push_back(letter());
        end
        default:    add_tag(p < pieces - 1);
      endcase
    end
    first_flag = ($urandom_range(0, 9) != 0);
    last_flag  = ($urandom_range(0, 9) != 0);
    file_pos   = 9'($urandom_range(0, 511));
    foreach (entry_bytes[i]) begin
      send_byte(entry_bytes[i], first_flag && i == 0,
                last_flag && i == entry_bytes.size() - 1);
    end
  endtask

  // register write once every owed result has arrived
  task automatic write_mode(input logic [1:0] m);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = m;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [1:0] phase_mode(input int ph);
    case (ph % 4)
      0:       return MODE_REPLAY;
      1:       return MODE_EH_STOP;
      2:       return MODE_DROP;
      default: return MODE_SPARE;
    endcase
  endfunction

  // stimulus
  initial begin
    int ph;
    int phase_end;
    int k;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    scrambled_byte = '0;
    offset_low     = '0;
    entry_first    = 1'b0;
    entry_last     = 1'b0;
    file_pos       = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: offset and byte extremes, accents, line feed, lone percent, inner at
    write_mode(MODE_DROP);
    file_pos = 9'd0;
    send_byte(8'h00, 1'b1, 1'b0);
    file_pos = 9'h1ff;
    send_byte(8'hff, 1'b0, 1'b0);
    for (k = 0; k < 7; k++) send_byte(accent_src(k), 1'b0, 1'b0);
    send_byte(CH_NL, 1'b0, 1'b0);
    send_byte(CH_PCT, 1'b0, 1'b0);
    send_byte("x", 1'b0, 1'b0);
    send_byte(CH_PCT, 1'b0, 1'b0);
    send_byte(CH_AT, 1'b0, 1'b0);
    send_byte("a", 1'b0, 1'b0);
    send_byte(CH_AT, 1'b0, 1'b0);
    send_byte("b", 1'b0, 1'b0);
    send_byte(CH_AT, 1'b0, 1'b0);
    send_byte(CH_PCT, 1'b0, 1'b0);
    send_byte("z", 1'b0, 1'b1);

    // directed: EH tag ends the entry with a line break, the byte after it gives nothing
    write_mode(MODE_EH_STOP);
    send_byte(CH_PCT, 1'b1, 1'b0);
    send_byte(CH_AT, 1'b0, 1'b0);
    send_byte(CH_E, 1'b0, 1'b0);
    send_byte(CH_H, 1'b0, 1'b0);
    send_byte(CH_AT, 1'b0, 1'b0);
    send_byte(CH_PCT, 1'b0, 1'b0);
    send_byte("q", 1'b0, 1'b1);

    // random phases, one mode each; first one holds the sink off, third has no gaps
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_mode(phase_mode(ph));
      if (ph == 0) hold_req = 1'b1;
      no_gaps   = (ph == 2);
      phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          file_pos = 9'($urandom_range(0, 511));
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          send_entry();
        end
      end
    end
    no_gaps  = 1'b0;
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### xor_descramble_tag_stripper_core.f
rtl/xdts_pkg.sv
rtl/xdts_decode.sv
rtl/xdts_tag_ram.sv
rtl/xor_descramble_tag_stripper_core.sv
rtl/xdts_checker.sv
tb/xdts_glyph_checker.sv
tb/xor_descramble_tag_stripper_core_tb.sv
